/* design/trc_pkg.sv */
// Shared types and constants for the temperature raw compensation block.
// Used by trc_front, trc_back and temperature_raw_compensation; no dependencies.
package trc_pkg;

    localparam int RAW_W       = 20;
    localparam int COEFF_W     = 16;
    localparam int TEMP_W      = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [RAW_W-1:0] SKIP_CODE = 20'h80000;

    // ceil(2^22 / 10): exact truncating divide by ten for magnitudes below 2^19
    localparam logic signed [19:0] RECIP_TEN   = 20'sd419431;
    localparam int                 RECIP_SHIFT = 22;

    localparam logic signed [TEMP_W:0] TEMP_MAX = 17'sd32767;
    localparam logic signed [TEMP_W:0] TEMP_MIN = -17'sd32768;

    localparam logic [1:0] CFG_OFFSET = 2'd0;
    localparam logic [1:0] CFG_LINEAR = 2'd1;
    localparam logic [1:0] CFG_SQUARE = 2'd2;

    typedef struct packed {
        logic             skip;
        logic [RAW_W-1:0] raw;
    } trc_item_t;

    typedef struct packed {
        logic        [COEFF_W-1:0] offset;
        logic signed [COEFF_W-1:0] linear;
        logic signed [COEFF_W-1:0] square;
    } trc_coeff_t;

endpackage

/* design/trc_front.sv */
// Input side: takes items, assembles the raw reading, flags bus errors and
// skip codes, and holds them in a short queue for the back end. Uses trc_pkg.
module trc_front
    import trc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  logic [7:0] raw_high,
    input  logic [7:0] raw_mid,
    input  logic [7:0] raw_low,
    input  logic      bus_error,
    output logic      q_valid,
    output trc_item_t q_item,
    input  logic      q_pop
);

    trc_item_t          item_q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    trc_item_t          new_item;
    logic               push;

    always_comb
    begin
        new_item.raw  = {raw_high, raw_mid, raw_low[7:4]};
        new_item.skip = bus_error || (new_item.raw == SKIP_CODE);
    end

    assign in_stall = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign q_item   = item_q_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            item_q_reg[wr_ptr_reg] <= new_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !q_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (q_pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue fill count beyond depth");

    a_count_push: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !q_pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not follow a push");

endmodule

/* design/trc_back.sv */
// Compensation sequencer: one shared 22x20 multiplier works through the
// calibration, divide by ten and saturation; drives the output register. Uses trc_pkg.
module trc_back
    import trc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  trc_coeff_t               coeff,
    input  logic                     q_valid,
    input  trc_item_t                q_item,
    output logic                     q_pop,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [TEMP_W-1:0] temp_tenths,
    output logic                     fresh
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LIN,
        S_SQ,
        S_SQ3,
        S_FINE,
        S_MAG,
        S_DIV,
        S_DONE
    } state_t;

    state_t                    state_reg;
    logic [RAW_W-1:0]          raw_reg;
    logic signed [41:0]        prod_reg;
    logic signed [22:0]        lin_reg;
    logic signed [18:0]        hund_reg;
    logic                      neg_reg;
    logic signed [TEMP_W-1:0]  res_temp_reg;
    logic                      res_fresh_reg;
    logic                      out_valid_reg;
    logic signed [TEMP_W-1:0]  out_temp_reg;
    logic                      out_fresh_reg;
    logic signed [TEMP_W-1:0]  last_good_reg;

    logic signed [21:0]        mul_a;
    logic signed [19:0]        mul_b;
    logic signed [41:0]        prod_full;
    logic signed [17:0]        lin_a;
    logic signed [16:0]        diff;
    logic signed [21:0]        sq;
    logic signed [23:0]        fine;
    logic signed [26:0]        fine5;
    logic [18:0]               mag;
    logic [14:0]               quot;
    logic signed [TEMP_W:0]    sres;
    logic signed [TEMP_W-1:0]  sat;
    logic                      out_free;

    assign lin_a = $signed({1'b0, raw_reg[19:3]}) - $signed({1'b0, coeff.offset, 1'b0});
    assign diff  = $signed({1'b0, raw_reg[19:4]}) - $signed({1'b0, coeff.offset});
    assign sq    = prod_reg[35:14];
    assign fine  = 24'(lin_reg) + 24'(sq);
    assign fine5 = (27'(fine) <<< 2) + 27'(fine) + 27'sd128;
    assign mag   = hund_reg[18] ? 19'(-hund_reg) : 19'(hund_reg);
    assign quot  = prod_reg[RECIP_SHIFT+14:RECIP_SHIFT];
    assign sres  = neg_reg ? -$signed({2'b00, quot}) : $signed({2'b00, quot});

    always_comb
    begin
        if (sres > TEMP_MAX)
        begin
            sat = TEMP_W'(TEMP_MAX);
        end
        else if (sres < TEMP_MIN)
        begin
            sat = TEMP_W'(TEMP_MIN);
        end
        else
        begin
            sat = sres[TEMP_W-1:0];
        end
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_LIN:
            begin
                mul_a = {{4{lin_a[17]}}, lin_a};
                mul_b = {{4{coeff.linear[15]}}, coeff.linear};
            end
            S_SQ:
            begin
                mul_a = {{5{diff[16]}}, diff};
                mul_b = {{3{diff[16]}}, diff};
            end
            S_SQ3:
            begin
                mul_a = {2'b00, prod_reg[31:12]};
                mul_b = {{4{coeff.square[15]}}, coeff.square};
            end
            S_MAG:
            begin
                mul_a = {3'b000, mag};
                mul_b = RECIP_TEN;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_full = mul_a * mul_b;
    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign out_free  = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            last_good_reg <= '0;
            raw_reg       <= '0;
            prod_reg      <= '0;
            lin_reg       <= '0;
            hund_reg      <= '0;
            neg_reg       <= 1'b0;
            res_temp_reg  <= '0;
            res_fresh_reg <= 1'b0;
            out_temp_reg  <= '0;
            out_fresh_reg <= 1'b0;
        end
        else
        begin
            prod_reg <= prod_full;
            if (out_valid_reg && !out_stall && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        raw_reg <= q_item.raw;
                        if (q_item.skip)
                        begin
                            res_temp_reg  <= last_good_reg;
                            res_fresh_reg <= 1'b0;
                            state_reg     <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_LIN;
                        end
                    end
                end
                S_LIN:
                begin
                    state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    lin_reg   <= prod_reg[33:11];
                    state_reg <= S_SQ3;
                end
                S_SQ3:
                begin
                    state_reg <= S_FINE;
                end
                S_FINE:
                begin
                    hund_reg  <= fine5[26:8];
                    state_reg <= S_MAG;
                end
                S_MAG:
                begin
                    neg_reg   <= hund_reg[18];
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    res_temp_reg  <= sat;
                    res_fresh_reg <= 1'b1;
                    state_reg     <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_temp_reg  <= res_temp_reg;
                        out_fresh_reg <= res_fresh_reg;
                        if (res_fresh_reg)
                        begin
                            last_good_reg <= res_temp_reg;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign temp_tenths = out_temp_reg;
    assign fresh       = out_fresh_reg;

    a_out_matches_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_temp_reg == last_good_reg)
        else $error("pending result differs from last good value");

    a_last_good_update: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(last_good_reg) |-> $past(state_reg == S_DONE && res_fresh_reg))
        else $error("last good value changed outside a fresh result");

endmodule

/* design/temperature_raw_compensation.sv */
// Top level of the temperature raw compensation block: configuration
// registers, front end with item queue, and compensation back end. Uses trc_pkg.
//
// Input channel: in_valid/in_stall carry raw_high, raw_mid, raw_low and bus_error.
// Output channel: out_valid/out_stall carry temp_tenths (0.1 degC, signed,
// saturated) and fresh; exactly one result item per input item, in order.
// Configuration: cfg_wr_en writes cfg_data into coefficient cfg_index
// (0 offset T1, 1 linear T2, 2 square T3); index 3 is ignored.
// A computed item steps through S_LIN, S_SQ, S_SQ3, S_FINE, S_MAG and S_DIV
// to S_DONE before out_valid, as the single shared multiplier is stepped
// through four products; a bus error or skip-code item goes from S_IDLE
// straight to S_DONE. A new item is popped only when the back end is idle.
// A two-entry queue lets the input side accept while the back end computes.
// When out_stall is high the finished result is held, the back end waits at
// its final step and the queue fills; in_stall rises once it is full.
// Reset clears the coefficients, the last good value, the queue and the
// output valid.
module temperature_raw_compensation
    import trc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [7:0]               raw_high,
    input  logic [7:0]               raw_mid,
    input  logic [7:0]               raw_low,
    input  logic                     bus_error,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [TEMP_W-1:0] temp_tenths,
    output logic                     fresh,
    input  logic                     cfg_wr_en,
    input  logic [1:0]               cfg_index,
    input  logic [COEFF_W-1:0]       cfg_data
);

    trc_coeff_t coeff_reg;
    trc_item_t  q_item;
    logic       q_valid;
    logic       q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_OFFSET: coeff_reg.offset <= cfg_data;
                CFG_LINEAR: coeff_reg.linear <= $signed(cfg_data);
                CFG_SQUARE: coeff_reg.square <= $signed(cfg_data);
                default:    coeff_reg        <= coeff_reg;
            endcase
        end
    end

    trc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .raw_high  (raw_high),
        .raw_mid   (raw_mid),
        .raw_low   (raw_low),
        .bus_error (bus_error),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    trc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .coeff       (coeff_reg),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .temp_tenths (temp_tenths),
        .fresh       (fresh)
    );

endmodule
